// ===== rtl/palb_pkg.sv =====
// ----------------------------------------------------------------------------
// palb_pkg: shared types and constants for the ping-pong audio level buffer
// Buffer geometry, register codes, transfer payload types and the
// reciprocal constants used by the level datapath.
// ----------------------------------------------------------------------------
package palb_pkg;

    // buffer geometry
    localparam int BUFFER_DEPTH = 512;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W       = IDX_W + 1;
    localparam int RAM_DEPTH    = 2 ** ADDR_W;

    // register widths
    localparam int LENGTH_W   = 10;
    localparam int GAIN_W     = 8;
    localparam int LEVEL_W    = 8;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // width that holds both the length register and the depth
    localparam int CMP_W = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;

    // register reset values
    localparam logic                RST_ENABLE = 1'b1;
    localparam logic [LENGTH_W-1:0] RST_LENGTH = 10'd441;
    localparam logic [GAIN_W-1:0]   RST_GAIN   = 8'd108;
    localparam logic                RST_MONO   = 1'b0;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // level datapath constants
    localparam logic signed [18:0] AMP_MAX  = 19'sd32767;
    localparam logic signed [18:0] AMP_MIN  = -19'sd32767;
    // floor(a / 127) = (a * 33027) >> 22 for a below 2^15
    localparam logic [15:0]        DIV127_MUL   = 16'd33027;
    localparam int                 DIV127_SHIFT = 22;
    // floor(y / 175) = (y * 47935) >> 23 for y below 2^16
    localparam logic [15:0]        DIV175_MUL   = 16'd47935;
    localparam int                 DIV175_SHIFT = 23;
    localparam logic [8:0]         LEVEL_CAP    = 9'd255;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_LENGTH = 2'd1,
        CFG_GAIN   = 2'd2,
        CFG_MONO   = 2'd3
    } cfg_reg_t;

    // control states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_WRITE,
        ST_READ,
        ST_RESP
    } palb_state_t;

    // input transfer
    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } in_item_t;

    // output transfer
    typedef struct packed {
        logic               accepted;
        logic               level_valid;
        logic [LEVEL_W-1:0] level;
    } out_item_t;

    // settings seen by the level datapath
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              mono_mode;
    } level_cfg_t;

endpackage

// ===== rtl/palb_ram.sv =====
// ----------------------------------------------------------------------------
// palb_ram: generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module palb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/palb_level.sv =====
// ----------------------------------------------------------------------------
// palb_level: drive level datapath
// Four register stages: mono mix and gain, saturation and divide by 127,
// square, divide by 700 and cap.
// ----------------------------------------------------------------------------
module palb_level (
    input  logic                          clk,
    input  palb_pkg::in_item_t            sample,
    input  palb_pkg::level_cfg_t          cfg,
    output logic [palb_pkg::LEVEL_W-1:0]  level
);

    logic signed [16:0] sum;
    logic signed [15:0] mix;
    logic signed [15:0] right_src;
    logic signed [8:0]  gain_s;
    logic signed [24:0] prod_reg;
    logic signed [18:0] amp;
    logic signed [18:0] amp_sat;
    logic [14:0]        mag;
    logic [30:0]        quot_reg;
    logic [8:0]         v;
    logic [16:0]        sq_reg;
    logic [17:0]        x3;
    logic [15:0]        x3_quarter;
    logic [31:0]        lvl_reg;
    logic [8:0]         lvl_raw;

    // stage 1: mono mix, floor halve, gain multiply
    always_comb
    begin
        right_src = cfg.mono_mode ? sample.left_sample : sample.right_sample;
        sum       = 17'(sample.left_sample) + 17'(right_src);
        mix       = 16'(sum >>> 1);
        gain_s    = signed'({1'b0, cfg.gain});
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mix * gain_s;
    end

    // stage 2: Q2.6 floor shift, saturate, magnitude, divide by 127
    always_comb
    begin
        amp = 19'(prod_reg >>> 6);
        priority if (amp > palb_pkg::AMP_MAX)
        begin
            amp_sat = palb_pkg::AMP_MAX;
        end
        else if (amp < palb_pkg::AMP_MIN)
        begin
            amp_sat = palb_pkg::AMP_MIN;
        end
        else
        begin
            amp_sat = amp;
        end
        mag = amp_sat[18] ? 15'(-amp_sat) : amp_sat[14:0];
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= 31'(mag) * 31'(palb_pkg::DIV127_MUL);
    end

    // stage 3: square
    assign v = quot_reg[palb_pkg::DIV127_SHIFT +: 9];

    always_ff @(posedge clk)
    begin
        sq_reg <= 17'(18'(v) * 18'(v));
    end

    // stage 4: times three, divide by 700 as quarter then by 175
    always_comb
    begin
        x3         = {sq_reg, 1'b0} + 18'(sq_reg);
        x3_quarter = x3[17:2];
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= 32'(x3_quarter) * 32'(palb_pkg::DIV175_MUL);
    end

    // cap at full scale
    assign lvl_raw = lvl_reg[palb_pkg::DIV175_SHIFT +: 9];
    assign level   = (lvl_raw > palb_pkg::LEVEL_CAP) ? palb_pkg::LEVEL_CAP[7:0] : lvl_raw[7:0];

endmodule

// ===== rtl/pingpong_audio_level_buffer.sv =====
// ----------------------------------------------------------------------------
// pingpong_audio_level_buffer: ping-pong drive level store
// Stereo pushes fill one buffer with 8-bit drive levels while ticks read
// the other; the buffers swap when the reader reaches the buffer length.
// ----------------------------------------------------------------------------
// Both buffers live in one RAM of 2 x BUFFER_DEPTH bytes (upper address bit
// selects the buffer). After reset a clearing pass writes zero to every RAM
// entry, one per cycle; in_ready stays low until it ends, configuration
// writes are taken throughout. Items are handled one at a time: a tick is
// accepted, then its RAM read data is loaded; a stored push passes accept,
// four stages of the level datapath, RAM write and result; a rejected push
// or a tick while disabled goes from accept to its result. The result sits
// in an output register, so the next item is taken while it waits; an item
// only stalls when its own result finds that register still full. The user
// must write configuration through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pingpong_audio_level_buffer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  palb_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output palb_pkg::out_item_t                out_data,
    input  logic                               cfg_we,
    input  logic [palb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [palb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration registers
    logic                              enable_reg;
    logic [palb_pkg::LENGTH_W-1:0]     length_reg;
    logic [palb_pkg::GAIN_W-1:0]       gain_reg;
    logic                              mono_reg;

    // control state
    palb_pkg::palb_state_t             state_reg, state_next;
    logic [palb_pkg::LEN_W-1:0]        wr_reg, wr_next;
    logic [palb_pkg::IDX_W-1:0]        rd_reg, rd_next;
    logic                              ps_reg, ps_next;
    logic [palb_pkg::ADDR_W-1:0]       clr_reg, clr_next;
    logic [1:0]                        cnt_reg, cnt_next;
    logic                              out_valid_reg, out_valid_next;

    // payload registers
    palb_pkg::in_item_t                samp_reg;
    palb_pkg::out_item_t               pend_reg, pend_next;
    palb_pkg::out_item_t               out_data_reg;
    palb_pkg::out_item_t               out_load_data;
    logic                              out_load;
    logic                              out_free;
    logic                              in_fire;

    // length and pointer compares
    logic [palb_pkg::CMP_W-1:0]        len_ext;
    logic [palb_pkg::CMP_W-1:0]        eff_len;
    logic [palb_pkg::CMP_W-1:0]        rd_inc;
    logic                              rd_wrap;
    logic                              push_ok;

    // ram and datapath signals
    logic                              ram_we;
    logic [palb_pkg::ADDR_W-1:0]       ram_waddr;
    logic [palb_pkg::LEVEL_W-1:0]      ram_wdata;
    logic                              ram_re;
    logic [palb_pkg::ADDR_W-1:0]       ram_raddr;
    logic [palb_pkg::LEVEL_W-1:0]      ram_rdata;
    logic [palb_pkg::LEVEL_W-1:0]      level;
    palb_pkg::level_cfg_t              level_cfg;

    localparam logic [palb_pkg::ADDR_W-1:0] CLR_LAST  = '1;
    localparam logic [1:0]                  CALC_LAST = 2'd3;

    // handshake
    assign in_ready  = (state_reg == palb_pkg::ST_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign out_free  = ~out_valid_reg | out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // effective length and pointer checks
    always_comb
    begin
        len_ext = palb_pkg::CMP_W'(length_reg);
        eff_len = (len_ext > palb_pkg::CMP_W'(palb_pkg::BUFFER_DEPTH))
                  ? palb_pkg::CMP_W'(palb_pkg::BUFFER_DEPTH) : len_ext;
        push_ok = enable_reg && (palb_pkg::CMP_W'(wr_reg) < eff_len);
        rd_inc  = palb_pkg::CMP_W'(rd_reg) + palb_pkg::CMP_W'(1);
        rd_wrap = (rd_inc >= eff_len);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= palb_pkg::RST_ENABLE;
            length_reg <= palb_pkg::RST_LENGTH;
            gain_reg   <= palb_pkg::RST_GAIN;
            mono_reg   <= palb_pkg::RST_MONO;
        end
        else if (cfg_we)
        begin
            unique case (palb_pkg::cfg_reg_t'(cfg_index))
                palb_pkg::CFG_ENABLE: enable_reg <= cfg_data[0];
                palb_pkg::CFG_LENGTH: length_reg <= cfg_data[palb_pkg::LENGTH_W-1:0];
                palb_pkg::CFG_GAIN:   gain_reg   <= cfg_data[palb_pkg::GAIN_W-1:0];
                palb_pkg::CFG_MONO:   mono_reg   <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            palb_pkg::ST_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = palb_pkg::ST_IDLE;
                end
            end
            palb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.cmd == palb_pkg::CMD_PUSH)
                    begin
                        state_next = push_ok ? palb_pkg::ST_CALC : palb_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = enable_reg ? palb_pkg::ST_READ : palb_pkg::ST_RESP;
                    end
                end
            end
            palb_pkg::ST_CALC:
            begin
                if (cnt_reg == CALC_LAST)
                begin
                    state_next = palb_pkg::ST_WRITE;
                end
            end
            palb_pkg::ST_WRITE:
            begin
                state_next = palb_pkg::ST_RESP;
            end
            palb_pkg::ST_READ, palb_pkg::ST_RESP:
            begin
                state_next = out_free ? palb_pkg::ST_IDLE : palb_pkg::ST_RESP;
            end
            default:
            begin
                state_next = palb_pkg::ST_IDLE;
            end
        endcase
    end

    // pointer updates, ram access and result staging
    always_comb
    begin
        wr_next       = wr_reg;
        rd_next       = rd_reg;
        ps_next       = ps_reg;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        out_load      = 1'b0;
        out_load_data = pend_reg;
        ram_we        = 1'b0;
        ram_waddr     = {~ps_reg, wr_reg[palb_pkg::IDX_W-1:0]};
        ram_wdata     = level;
        ram_re        = 1'b0;
        ram_raddr     = {ps_reg, rd_reg};
        unique case (state_reg)
            palb_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + palb_pkg::ADDR_W'(1);
            end
            palb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cnt_next  = '0;
                    pend_next = '0;
                    // tick: read the play buffer and advance the reader
                    if ((in_data.cmd == palb_pkg::CMD_TICK) && enable_reg)
                    begin
                        ram_re = 1'b1;
                        if (rd_wrap)
                        begin
                            rd_next = '0;
                            wr_next = '0;
                            ps_next = ~ps_reg;
                        end
                        else
                        begin
                            rd_next = rd_inc[palb_pkg::IDX_W-1:0];
                        end
                    end
                end
            end
            palb_pkg::ST_CALC:
            begin
                cnt_next = cnt_reg + 2'd1;
            end
            palb_pkg::ST_WRITE:
            begin
                // store the level in the fill buffer
                ram_we    = 1'b1;
                wr_next   = wr_reg + palb_pkg::LEN_W'(1);
                pend_next = palb_pkg::out_item_t'{accepted: 1'b1, level_valid: 1'b0,
                                                  level: '0};
            end
            palb_pkg::ST_READ:
            begin
                out_load_data = palb_pkg::out_item_t'{accepted: 1'b0, level_valid: 1'b1,
                                                      level: ram_rdata};
                pend_next     = out_load_data;
                out_load      = out_free;
            end
            palb_pkg::ST_RESP:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    assign out_valid_next = out_load | (out_valid_reg & ~out_ready);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= palb_pkg::ST_CLEAR;
            wr_reg        <= '0;
            rd_reg        <= '0;
            ps_reg        <= 1'b0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            ps_reg        <= ps_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            samp_reg <= in_data;
        end
        pend_reg <= pend_next;
        if (out_load)
        begin
            out_data_reg <= out_load_data;
        end
    end

    // level datapath
    assign level_cfg = palb_pkg::level_cfg_t'{gain: gain_reg, mono_mode: mono_reg};

    palb_level u_level (
        .clk    (clk),
        .sample (samp_reg),
        .cfg    (level_cfg),
        .level  (level)
    );

    // both buffers in one ram
    palb_ram #(
        .WIDTH (palb_pkg::LEVEL_W),
        .DEPTH (palb_pkg::RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== rtl/palb_checker.sv =====
// ----------------------------------------------------------------------------
// palb_checker: port-level assertions for the ping-pong level buffer
// Watches the transfer and reset behavior seen at the top level ports.
// ----------------------------------------------------------------------------
module palb_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input palb_pkg::out_item_t                out_data
);

    // one item in flight: an input transfer closes the input side
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken on the cycle after a transfer");

    // clearing pass holds off input right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("input ready before buffer clear");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");

    // only a tick result carries a level
    a_level_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.accepted || !out_data.level_valid))
        |-> (out_data.level == 8'd0))
        else $error("level set on a non-tick result");

    // push and tick flags never both set
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.accepted && out_data.level_valid))
        else $error("accepted and level_valid both set");

endmodule

bind pingpong_audio_level_buffer palb_checker u_palb_checker (.*);
